>>> design/hcbc_pkg.sv
// Package for the HSV color band classifier: payload structs, band layout,
// register indexes and class codes. No dependencies.
package hcbc_pkg;

    localparam int BandCount = 5;
    localparam int BandWidth = 58;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [2:0]  color_class;
        logic [10:0] hue;
        logic        hue_undefined;
        logic [8:0]  saturation;
        logic [8:0]  brightness;
    } t_result;

    typedef struct packed {
        logic [8:0]  val_hi;
        logic [8:0]  val_lo;
        logic [8:0]  sat_hi;
        logic [8:0]  sat_lo;
        logic [10:0] hue_hi;
        logic [10:0] hue_lo;
    } t_band;

    typedef enum logic [2:0] {
        REG_RED    = 3'd0,
        REG_GREEN  = 3'd1,
        REG_BLUE   = 3'd2,
        REG_YELLOW = 3'd3,
        REG_ORANGE = 3'd4
    } t_reg_index;

    typedef enum logic [2:0] {
        CLASS_NONE   = 3'd0,
        CLASS_RED    = 3'd1,
        CLASS_GREEN  = 3'd2,
        CLASS_BLUE   = 3'd3,
        CLASS_YELLOW = 3'd4,
        CLASS_ORANGE = 3'd5
    } t_class;

    // Operands handed from the front stages to the divider stages.
    typedef struct packed {
        logic        valid;
        logic        undef;
        logic [7:0]  d;
        logic [7:0]  mx;
        logic [18:0] hue_num;
        logic [8:0]  val;
    } t_div;

endpackage

>>> design/hcbc_front.sv
// Front stages: max/min/delta, hue numerator and brightness.
// Depends on hcbc_pkg.
module hcbc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hcbc_pkg::t_pixel i_pixel,
    output hcbc_pkg::t_div  o_div
);
    import hcbc_pkg::*;

    logic       r_v1;
    t_pixel     r_px;
    logic [7:0] r_mx, r_mn;
    logic [7:0] n_mx, n_mn;
    logic [1:0] n_sel;
    logic [1:0] r_sel;

    always_comb begin
        n_mx = i_pixel.red;
        n_sel = 2'd0;
        if (i_pixel.green > n_mx) begin
            n_mx = i_pixel.green;
            n_sel = 2'd1;
        end
        if (i_pixel.blue > n_mx) begin
            n_mx = i_pixel.blue;
            n_sel = 2'd2;
        end
        n_mn = i_pixel.red;
        if (i_pixel.green < n_mn) n_mn = i_pixel.green;
        if (i_pixel.blue < n_mn) n_mn = i_pixel.blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_px  <= i_pixel;
        r_mx  <= n_mx;
        r_mn  <= n_mn;
        r_sel <= n_sel;
    end

    // Hue numerator: base*d plus 240 times the signed channel difference,
    // at most 1440*255.
    logic [7:0]  w_d;
    logic [18:0] n_num;
    logic [8:0]  n_diff;
    logic [10:0] n_base;
    logic [18:0] n_bd;
    logic [18:0] n_dd;

    always_comb begin
        w_d = r_mx - r_mn;
        n_base = 11'd0;
        n_diff = 9'd0;
        unique case (r_sel)
            2'd0: begin
                n_base = 11'd0;
                n_diff = {1'b0, r_px.green} - {1'b0, r_px.blue};
                if (r_px.green < r_px.blue) n_base = 11'd1440;
            end
            2'd1: begin
                n_base = 11'd480;
                n_diff = {1'b0, r_px.blue} - {1'b0, r_px.red};
            end
            default: begin
                n_base = 11'd960;
                n_diff = {1'b0, r_px.red} - {1'b0, r_px.green};
            end
        endcase
        n_bd = 19'(n_base) * 19'(w_d);
        n_dd = 19'($signed({{10{n_diff[8]}}, n_diff}) * 19'sd240);
        n_num = n_bd + n_dd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_div.valid <= 1'b0;
        end else begin
            o_div.valid <= r_v1;
        end
        o_div.undef   <= (w_d == 8'd0);
        o_div.d       <= w_d;
        o_div.mx      <= r_mx;
        o_div.hue_num <= n_num;
        o_div.val     <= (r_mx == 8'hFF) ? 9'd256 : {1'b0, r_mx};
    end
endmodule

>>> design/hcbc_div.sv
// Restoring division stages: hue = num/d (19b/8b) and sat = 256*d/mx.
// Depends on hcbc_pkg; each stage resolves up to four quotient bits per operand.
module hcbc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hcbc_pkg::t_div i_div,
    output logic           o_valid,
    output logic           o_undef,
    output logic [10:0]    o_hue,
    output logic [8:0]     o_sat,
    output logic [8:0]     o_val
);
    import hcbc_pkg::*;

    // Hue: 19 dividend bits shifted in MSB first, quotient builds in the low
    // bits. Sat: 17-bit dividend d<<8 over mx, quotient fits 9 bits.
    localparam int Steps = 20;
    localparam int HueSteps = 19;
    localparam int SatSteps = 17;
    localparam int PerStage = 4;
    localparam int NStg = Steps / PerStage;

    typedef struct packed {
        logic [8:0]  hr;
        logic [18:0] hn;
        logic [8:0]  sr;
        logic [16:0] sn;
    } t_quo;

    function automatic t_quo div_stage(t_quo q, logic [7:0] d, logic [7:0] mx, int first);
        t_quo t;
        t = q;
        for (int k = 0; k < PerStage; k++) begin
            if (first + k < HueSteps) begin
                t.hr = {t.hr[7:0], t.hn[18]};
                t.hn = {t.hn[17:0], 1'b0};
                if (t.hr >= {1'b0, d}) begin
                    t.hr = t.hr - {1'b0, d};
                    t.hn[0] = 1'b1;
                end
            end
            if (first + k < SatSteps) begin
                t.sr = {t.sr[7:0], t.sn[16]};
                t.sn = {t.sn[15:0], 1'b0};
                if (t.sr >= {1'b0, mx} && mx != 8'd0) begin
                    t.sr = t.sr - {1'b0, mx};
                    t.sn[0] = 1'b1;
                end
            end
        end
        return t;
    endfunction

    logic [NStg-1:0] r_v;
    logic [NStg-1:0] r_u;
    t_quo            r_q   [NStg];
    t_quo            n_q   [NStg];
    logic [7:0]      r_d   [NStg];
    logic [7:0]      r_mx  [NStg];
    logic [8:0]      r_val [NStg];

    always_comb begin
        n_q[0] = div_stage({9'd0, i_div.hue_num, 9'd0, {1'b0, i_div.d, 8'd0}},
                           i_div.d, i_div.mx, 0);
        for (int s = 1; s < NStg; s++) begin
            n_q[s] = div_stage(r_q[s-1], r_d[s-1], r_mx[s-1], s * PerStage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NStg-2:0], i_div.valid};
        end
        r_u      <= {r_u[NStg-2:0], i_div.undef};
        r_q      <= n_q;
        r_d[0]   <= i_div.d;
        r_mx[0]  <= i_div.mx;
        r_val[0] <= i_div.val;
        for (int s = 1; s < NStg; s++) begin
            r_d[s]   <= r_d[s-1];
            r_mx[s]  <= r_mx[s-1];
            r_val[s] <= r_val[s-1];
        end
    end

    assign o_valid = r_v[NStg-1];
    assign o_undef = r_u[NStg-1];
    assign o_hue   = r_u[NStg-1] ? 11'd0 : r_q[NStg-1].hn[10:0];
    assign o_sat   = r_q[NStg-1].sn[8:0];
    assign o_val   = r_val[NStg-1];
endmodule

>>> design/hsv_color_band_classifier.sv
// HSV color band classifier: 8 register stages (2 front, 5 divide, 1 classify).
// o_done follows the start transfer through these stages; one pixel per cycle.
// The receiver cannot stall; o_done pulses for one cycle per pixel.
// Synchronous active-low reset clears valid bits and all band registers to 0.
// Depends on hcbc_pkg, hcbc_front, hcbc_div.
module hsv_color_band_classifier (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  hcbc_pkg::t_pixel      i_pixel,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [57:0]           i_cfg_data,
    output logic                  o_done,
    output hcbc_pkg::t_result     o_result
);
    import hcbc_pkg::*;

    t_band r_band [BandCount];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BandCount; i++) r_band[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_RED:    r_band[0] <= i_cfg_data;
                REG_GREEN:  r_band[1] <= i_cfg_data;
                REG_BLUE:   r_band[2] <= i_cfg_data;
                REG_YELLOW: r_band[3] <= i_cfg_data;
                REG_ORANGE: r_band[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    t_div       w_div;
    logic       w_v, w_u;
    logic [10:0] w_hue;
    logic [8:0]  w_sat, w_val;

    hcbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_pixel (i_pixel),
        .o_div   (w_div)
    );

    hcbc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_div    (w_div),
        .o_valid  (w_v),
        .o_undef  (w_u),
        .o_hue    (w_hue),
        .o_sat    (w_sat),
        .o_val    (w_val)
    );

    logic [BandCount-1:0] w_hit;
    always_comb begin
        for (int i = 0; i < BandCount; i++) begin
            logic hue_ok;
            hue_ok = (r_band[i].hue_lo > r_band[i].hue_hi)
                ? (w_hue > r_band[i].hue_lo || w_hue < r_band[i].hue_hi)
                : (w_hue > r_band[i].hue_lo && w_hue < r_band[i].hue_hi);
            w_hit[i] = hue_ok && !w_u
                && w_sat > r_band[i].sat_lo && w_sat < r_band[i].sat_hi
                && w_val > r_band[i].val_lo && w_val < r_band[i].val_hi;
        end
    end

    t_class n_cls;
    always_comb begin
        priority if (w_hit[0]) n_cls = CLASS_RED;
        else if (w_hit[1])     n_cls = CLASS_GREEN;
        else if (w_hit[2])     n_cls = CLASS_BLUE;
        else if (w_hit[3])     n_cls = CLASS_YELLOW;
        else if (w_hit[4])     n_cls = CLASS_ORANGE;
        else                   n_cls = CLASS_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_v;
        end
        o_result.color_class   <= n_cls;
        o_result.hue           <= w_hue;
        o_result.hue_undefined <= w_u;
        o_result.saturation    <= w_sat;
        o_result.brightness    <= w_val;
    end

    a_undef_no_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.hue_undefined |-> o_result.color_class == CLASS_NONE)
        else $error("class on undefined hue");
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.hue < 11'd1440)
        else $error("hue out of range");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##8 o_done)
        else $error("done missing");
endmodule
